[hdl/b32k_pkg.sv]
package b32k_pkg;

    // Symbol and character constants
    localparam logic [4:0] SYM_MASK       = 5'h1F;
    localparam logic [4:0] SYM_FIRST_J    = 5'd8;
    localparam logic [4:0] SYM_FIRST_P    = 5'd13;
    localparam logic [4:0] SYM_FIRST_DIG  = 5'd24;
    localparam logic [7:0] CHAR_A         = 8'h41;
    localparam logic [7:0] CHAR_J         = 8'h4A;
    localparam logic [7:0] CHAR_P         = 8'h50;
    localparam logic [7:0] CHAR_2         = 8'h32;
    localparam logic [7:0] CHAR_DASH      = 8'h2D;
    localparam int         GROUP_LEN      = 5;
    localparam int         MAX_RUN        = 4;
    localparam int         MAX_SYM        = 3;

    // One buffered output character
    typedef struct packed {
        logic [7:0] key_char;
        logic       end_of_key;
    } t_out_entry;

    // Map a 5-bit symbol to its alphabet character (no I, no O, then 2-9)
    function automatic logic [7:0] sym_to_ascii(input logic [4:0] v);
        logic [7:0] v8;
        v8 = {3'b000, v & SYM_MASK};
        if (v < SYM_FIRST_J) begin
            return CHAR_A + v8;
        end else if (v < SYM_FIRST_P) begin
            return CHAR_J + (v8 - {3'b000, SYM_FIRST_J});
        end else if (v < SYM_FIRST_DIG) begin
            return CHAR_P + (v8 - {3'b000, SYM_FIRST_P});
        end else begin
            return CHAR_2 + (v8 - {3'b000, SYM_FIRST_DIG});
        end
    endfunction

endpackage

[hdl/base32_key_encoder.sv]
// Base32 key encoder. Bytes come in on the input channel, least significant
// bit first, and leave as 5-bit symbols mapped to A-Z without I and O, then
// 2-9; the byte flagged final flushes remaining bits as one zero-padded
// symbol and clears all state for the next key. With group_dashes set, a
// dash follows every fifth character except the last of the key. Each
// request is decoded into a run of 1 to 4 characters held in a small run
// buffer, and the output register sends one character per cycle while
// i_out_stall is low. The next request is taken in the same cycle that the
// last character of the current run moves to the output register.
// end_of_run marks the last character of each request, end_of_key the final
// character of the key. Configuration should be written while idle.
module base32_key_encoder
    import b32k_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration write
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_data,
    // input bytes
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_final_byte,
    // output characters
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_key_char,
    output logic       o_end_of_key,
    output logic       o_end_of_run
);

    logic             r_group_dashes;
    logic [3:0]       r_left_bits;
    logic [2:0]       r_left_cnt;
    logic [2:0]       r_grp_pos;

    t_out_entry       r_buf [MAX_RUN];
    logic [2:0]       r_buf_left;

    logic             r_out_valid;
    logic [7:0]       r_out_char;
    logic             r_out_eok;
    logic             r_out_eor;

    logic             out_free;
    logic             buf_move;
    logic             in_ready;
    logic             in_accept;

    t_out_entry       n_run [MAX_RUN];
    logic [2:0]       n_run_cnt;
    logic [3:0]       n_left_bits;
    logic [2:0]       n_left_cnt;
    logic [2:0]       n_grp_pos;

    // Configuration register, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_dashes <= 1'b0;
        end else if (i_cfg_valid) begin
            r_group_dashes <= i_cfg_data;
        end
    end

    // Handshake control
    assign out_free   = !r_out_valid || !i_out_stall;
    assign buf_move   = out_free && (r_buf_left != 3'd0);
    assign in_ready   = (r_buf_left == 3'd0) || ((r_buf_left == 3'd1) && out_free);
    assign in_accept  = i_in_valid && in_ready;
    assign o_in_stall = !in_ready;

    // Decode one byte into its run of characters and the next state
    always_comb begin
        logic [14:0] acc;
        logic [1:0]  base_sym;
        logic [2:0]  rem_bits;
        logic [1:0]  nsym;
        logic [2:0]  pos;
        logic [2:0]  cnt;
        logic        last;

        acc      = 15'({4'b0000, i_data_byte} << r_left_cnt) | 15'(r_left_bits);
        base_sym = (r_left_cnt >= 3'd2) ? 2'd2 : 2'd1;
        unique case (r_left_cnt)
            3'd0:    rem_bits = 3'd3;
            3'd1:    rem_bits = 3'd4;
            3'd2:    rem_bits = 3'd0;
            3'd3:    rem_bits = 3'd1;
            3'd4:    rem_bits = 3'd2;
            default: rem_bits = 3'd0;
        endcase
        nsym = base_sym + {1'b0, (i_final_byte && (rem_bits != 3'd0))};

        for (int k = 0; k < MAX_RUN; k++) begin
            n_run[k] = '0;
        end
        pos  = r_grp_pos;
        cnt  = 3'd0;
        last = 1'b0;
        for (int i = 0; i < MAX_SYM; i++) begin
            if (2'(i) < nsym) begin
                last = i_final_byte && (2'(i) == nsym - 2'd1);
                n_run[cnt[1:0]].key_char   = sym_to_ascii(acc[5*i +: 5]);
                n_run[cnt[1:0]].end_of_key = last;
                cnt = cnt + 3'd1;
                pos = (pos == 3'(GROUP_LEN - 1)) ? 3'd0 : pos + 3'd1;
                if ((pos == 3'd0) && r_group_dashes && !last) begin
                    n_run[cnt[1:0]].key_char   = CHAR_DASH;
                    n_run[cnt[1:0]].end_of_key = 1'b0;
                    cnt = cnt + 3'd1;
                end
            end
        end
        n_run_cnt = cnt;

        if (i_final_byte) begin
            n_left_bits = 4'd0;
            n_left_cnt  = 3'd0;
            n_grp_pos   = 3'd0;
        end else begin
            n_left_bits = (base_sym == 2'd2) ? acc[13:10] : acc[8:5];
            n_left_cnt  = rem_bits;
            n_grp_pos   = pos;
        end
    end

    // Packing state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_bits <= 4'd0;
            r_left_cnt  <= 3'd0;
            r_grp_pos   <= 3'd0;
        end else if (in_accept) begin
            r_left_bits <= n_left_bits;
            r_left_cnt  <= n_left_cnt;
            r_grp_pos   <= n_grp_pos;
        end
    end

    // Run buffer: loaded per request, shifts one entry per output transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf_left <= 3'd0;
        end else if (in_accept) begin
            r_buf_left <= n_run_cnt;
        end else if (buf_move) begin
            r_buf_left <= r_buf_left - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            for (int k = 0; k < MAX_RUN; k++) begin
                r_buf[k] <= n_run[k];
            end
        end else if (buf_move) begin
            for (int k = 0; k < MAX_RUN - 1; k++) begin
                r_buf[k] <= r_buf[k + 1];
            end
            r_buf[MAX_RUN - 1] <= '0;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= buf_move;
        end
    end

    always_ff @(posedge i_clk) begin
        if (buf_move) begin
            r_out_char <= r_buf[0].key_char;
            r_out_eok  <= r_buf[0].end_of_key;
            r_out_eor  <= (r_buf_left == 3'd1);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_key_char   = r_out_char;
    assign o_end_of_key = r_out_eok;
    assign o_end_of_run = r_out_eor;

    // Checks
    a_buf_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_buf_left <= 3'(MAX_RUN))
        else $error("run buffer count out of range");

    a_left_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left_cnt <= 3'd4 && r_grp_pos <= 3'(GROUP_LEN - 1))
        else $error("packing state out of range");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_buf_left != 3'd0))
        else $error("accepted request produced no characters");

    a_eok_is_eor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_eok) |-> r_out_eor)
        else $error("end of key without end of run");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_buf_left > 3'd1) |-> !in_ready)
        else $error("request accepted over a pending run");

endmodule
